/* hw/rtl/image_diff_posterize_sharpen_top_macros.svh */
// ----------------------------------------------------------------------------
// image diff posterize sharpen assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef IMAGE_DIFF_POSTERIZE_SHARPEN_TOP_MACROS_SVH
`define IMAGE_DIFF_POSTERIZE_SHARPEN_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define IDPS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// condition must never be seen outside reset
`define IDPS_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);
`else
`define IDPS_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define IDPS_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif

`endif

/* hw/rtl/idps_pkg.sv */
// ----------------------------------------------------------------------------
// idps_pkg
// shared types, constants and level helpers of the diff posterize sharpen block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idps_pkg;

  // frame geometry
  localparam int IMAGE_WIDTH  = 64;
  localparam int IMAGE_HEIGHT = 64;
  localparam int FRAME_PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;

  localparam int COL_W = $clog2(IMAGE_WIDTH);
  localparam int ROW_W = $clog2(IMAGE_HEIGHT);
  localparam int CNT_W = $clog2(FRAME_PIXELS + 1);

  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(IMAGE_HEIGHT - 1);
  localparam logic [CNT_W-1:0] FRAME_CNT  = CNT_W'(FRAME_PIXELS);
  localparam logic [CNT_W-1:0] EMIT_START = CNT_W'(IMAGE_WIDTH + 1);

  // thresholds
  localparam int THR_W = 9;
  localparam logic [THR_W-1:0] LOW_THRESHOLD_RESET  = THR_W'(32);
  localparam logic [THR_W-1:0] HIGH_THRESHOLD_RESET = THR_W'(96);

  // posterize levels
  localparam logic [7:0] LEVEL_ZERO = 8'd0;
  localparam logic [7:0] LEVEL_MID  = 8'd128;
  localparam logic [7:0] LEVEL_FULL = 8'd255;

  typedef logic [1:0] code_t;
  localparam code_t CODE_ZERO = 2'd0;
  localparam code_t CODE_MID  = 2'd1;
  localparam code_t CODE_FULL = 2'd2;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    CFG_LOW_THRESHOLD  = 1'b0,
    CFG_HIGH_THRESHOLD = 1'b1
  } cfg_index_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] posterized;
    logic [7:0] sharpened;
    logic       frame_last;
  } out_item_t;

  function automatic logic [7:0] level_of(input code_t code);
    logic [7:0] lvl;
    case (code)
      CODE_MID:  lvl = LEVEL_MID;
      CODE_FULL: lvl = LEVEL_FULL;
      default:   lvl = LEVEL_ZERO;
    endcase
    return lvl;
  endfunction

  function automatic code_t posterize(input logic [7:0] a, input logic [7:0] b,
                                      input logic [THR_W-1:0] low_thr,
                                      input logic [THR_W-1:0] high_thr);
    logic [7:0] diff;
    code_t      code;
    diff = (a >= b) ? (a - b) : (b - a);
    if ({1'b0, diff} < low_thr) begin
      code = CODE_ZERO;
    end else if ({1'b0, diff} < high_thr) begin
      code = CODE_MID;
    end else begin
      code = CODE_FULL;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/image_diff_posterize_sharpen_top.sv */
// ----------------------------------------------------------------------------
// image_diff_posterize_sharpen_top
// absolute difference, three-level posterize and 3x3 sharpen on a pixel stream
// ----------------------------------------------------------------------------
// Takes one item per clock if not stalled: pixel pairs of a frame in raster order,
// then drain items that flush the tail. Each accepted item runs through a
// two-stage read-modify-write pipeline around the line store (a one-port-read,
// one-port-write memory of IMAGE_WIDTH entries, each holding the two lines
// above as 2-bit level codes): the accept cycle posterizes the pair and reads
// the entry of its column, the next cycle shifts the 3x3 window, writes the
// entry back and forms the sharpen result. Each result is registered into the
// result queue from the window stage; the first result of a frame comes with
// pixel IMAGE_WIDTH+2, and IMAGE_WIDTH+1 drain items deliver the remainder.
// A two-entry result queue sits at the output; once it holds one result and
// another is on its way from the window stage, an output stall raises in_stall
// in the same cycle, and in_stall drops once takes leave room for one more result.
// No memory clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "image_diff_posterize_sharpen_top_macros.svh"

module image_diff_posterize_sharpen_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input item channel
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire idps_pkg::in_item_t            in_item,
  // result item channel
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      idps_pkg::out_item_t           out_item,
  // register writes
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire idps_pkg::cfg_index_t          cfg_index,
  input  wire logic [idps_pkg::THR_W-1:0]    cfg_data
);
  import idps_pkg::*;

  // threshold registers
  logic [THR_W-1:0] low_threshold;
  logic [THR_W-1:0] high_threshold;

  // accept stage counters
  logic [CNT_W-1:0] in_count, in_count_next;
  logic [COL_W-1:0] wcol, wcol_next;
  logic [COL_W-1:0] out_col, out_col_next;
  logic [ROW_W-1:0] out_row, out_row_next;

  // window stage registers
  logic             s1_valid;
  logic             s1_emit;
  code_t            s1_code;
  logic [COL_W-1:0] s1_col;
  logic             s1_border;
  logic             s1_last;

  // line store, entry = {row n-2 code, row n-1 code}
  logic [3:0]       line_store [IMAGE_WIDTH];
  logic [3:0]       line_rdata;
  logic             fwd_hit;
  logic [3:0]       fwd_data;
  logic [3:0]       line_cur;
  logic [3:0]       line_wdata;

  // window: right column rows 0..2 plus centre-left
  code_t            win_top, win_mid, win_bot, win_left;

  // result queue
  out_item_t        ob_q0, ob_q1;
  logic [1:0]       ob_count;
  logic             push, pop;
  out_item_t        res;

  logic             accept;
  logic             is_pixel;
  logic             full;
  logic             do_shift;
  logic             do_emit;
  logic             a_last;
  logic             a_border;
  code_t            a_code;

  logic [7:0]       lv_c, lv_u, lv_d, lv_l, lv_r;
  logic signed [11:0] sharp_acc;
  logic [7:0]       sharp_clip;

  // ---------------------------------------------------------------------------
  // configuration, always ready; the block does not enforce it, but writes must come only while idle
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= LOW_THRESHOLD_RESET;
      high_threshold <= HIGH_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // accept stage: decide shift / emit, posterize, issue line store read
  // ---------------------------------------------------------------------------
  // stall only when the queue cannot take the result pending in the window
  // stage plus one more from this cycle
  assign pop      = out_valid && !out_stall;
  assign in_stall = ((ob_count == 2'd2) && (s1_emit || !pop)) ||
                    ((ob_count == 2'd1) && s1_emit && !pop);
  assign accept   = in_valid && !in_stall;

  assign is_pixel = (in_item.op == OP_PIXEL);
  assign full     = (in_count == FRAME_CNT);
  // pixels past frame end and drains before frame end are dropped
  assign do_shift = is_pixel ? !full : full;
  assign do_emit  = is_pixel ? (!full && (in_count >= EMIT_START)) : full;
  assign a_code   = is_pixel ?
                    posterize(in_item.pixel_a, in_item.pixel_b, low_threshold, high_threshold)
                    : CODE_ZERO;
  assign a_last   = (out_row == ROW_LAST) && (out_col == COL_LAST);
  assign a_border = (out_row == '0) || (out_row == ROW_LAST) ||
                    (out_col == '0) || (out_col == COL_LAST);

  always_comb begin
    in_count_next = in_count;
    wcol_next     = wcol;
    out_col_next  = out_col;
    out_row_next  = out_row;
    if (accept && do_shift) begin
      wcol_next = (wcol == COL_LAST) ? '0 : wcol + 1'b1;
      if (is_pixel) begin
        in_count_next = in_count + 1'b1;
      end
    end
    if (accept && do_emit) begin
      if (out_col == COL_LAST) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
      // frame done: everything restarts at the top-left
      if (a_last) begin
        in_count_next = '0;
        wcol_next     = '0;
        out_col_next  = '0;
        out_row_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count <= '0;
      wcol     <= '0;
      out_col  <= '0;
      out_row  <= '0;
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      in_count <= in_count_next;
      wcol     <= wcol_next;
      out_col  <= out_col_next;
      out_row  <= out_row_next;
      s1_valid <= accept && do_shift;
      s1_emit  <= accept && do_emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_code   <= a_code;
    s1_col    <= wcol;
    s1_border <= a_border;
    s1_last   <= a_last;
  end

  // ---------------------------------------------------------------------------
  // line store: read at the accept column; the window stage writes it back in the next cycle, no later
  // ---------------------------------------------------------------------------
  assign line_cur   = fwd_hit ? fwd_data : line_rdata;
  // entry moves up one row, new code enters the lower row
  assign line_wdata = {line_cur[1:0], s1_code};

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_store[s1_col] <= line_wdata;
    end
    line_rdata <= line_store[wcol];
  end

  // same-column write and read in one cycle (only at a frame wrap) forwards
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= s1_valid && (s1_col == wcol);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= line_wdata;
  end

  // ---------------------------------------------------------------------------
  // window stage: shift window, form sharpen result from pre-shift taps
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      win_top  <= CODE_ZERO;
      win_mid  <= CODE_ZERO;
      win_bot  <= CODE_ZERO;
      win_left <= CODE_ZERO;
    end else if (s1_valid) begin
      win_left <= win_mid;
      win_top  <= line_cur[3:2];
      win_mid  <= line_cur[1:0];
      win_bot  <= s1_code;
    end
  end

  // after the shift the centre is the old right-middle tap, the right
  // neighbour is the row n-1 code just read
  assign lv_c = level_of(win_mid);
  assign lv_u = level_of(win_top);
  assign lv_d = level_of(win_bot);
  assign lv_l = level_of(win_left);
  assign lv_r = level_of(line_cur[1:0]);

  assign sharp_acc = $signed({2'b00, lv_c, 2'b00}) + $signed({4'b0000, lv_c})
                   - $signed({4'b0000, lv_u}) - $signed({4'b0000, lv_d})
                   - $signed({4'b0000, lv_l}) - $signed({4'b0000, lv_r});

  always_comb begin
    if (sharp_acc < 0) begin
      sharp_clip = 8'd0;
    end else if (sharp_acc > 12'sd255) begin
      sharp_clip = 8'd255;
    end else begin
      sharp_clip = sharp_acc[7:0];
    end
  end

  assign res.posterized = lv_c;
  assign res.sharpened  = s1_border ? lv_c : sharp_clip;
  assign res.frame_last = s1_last;

  // ---------------------------------------------------------------------------
  // two-entry result queue
  // ---------------------------------------------------------------------------
  assign push      = s1_emit;
  assign out_valid = (ob_count != 2'd0);
  assign out_item  = ob_q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_count <= 2'd0;
    end else if (push && !pop) begin
      ob_count <= ob_count + 2'd1;
    end else if (pop && !push) begin
      ob_count <= ob_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (ob_count == 2'd0) begin
        ob_q0 <= res;
      end else begin
        ob_q1 <= res;
      end
    end else if (pop && !push) begin
      ob_q0 <= ob_q1;
    end else if (pop && push) begin
      if (ob_count == 2'd1) begin
        ob_q0 <= res;
      end else begin
        ob_q0 <= ob_q1;
        ob_q1 <= res;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `IDPS_ASSERT_NEVER(a_queue_overflow, clk, rst, push && (ob_count == 2'd2) && !pop, "result queue overflow")
  `IDPS_ASSERT_NEVER(a_count_range, clk, rst, in_count > FRAME_CNT, "pixel count past frame size")
  `IDPS_ASSERT(a_emit_shifts, clk, rst, s1_emit |-> s1_valid, "result without window shift")
  `IDPS_ASSERT(a_last_border, clk, rst, (out_valid && out_item.frame_last) |-> (out_item.sharpened == out_item.posterized), "last pixel not passed as border")
  `IDPS_ASSERT(a_level_set, clk, rst, out_valid |-> ((out_item.posterized == LEVEL_ZERO) || (out_item.posterized == LEVEL_MID) || (out_item.posterized == LEVEL_FULL)), "posterized level out of set")

endmodule

`default_nettype wire
